// ----- src/clock_servo_fractional_divider_assert.svh -----
// Assertion macros for the clock servo fractional divider.
// Every macro expects clk and rst_n in the scope where it is used.
`ifndef CLOCK_SERVO_FRACTIONAL_DIVIDER_ASSERT_SVH
`define CLOCK_SERVO_FRACTIONAL_DIVIDER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define CSFD_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define CSFD_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- src/csfd_pkg.sv -----
// Shared types and constants for the clock servo fractional divider.
// It has no dependencies and is imported by the top level.
`timescale 1ns / 1ps
`default_nettype none
package csfd_pkg;

  localparam int FRAC_BITS     = 44;
  localparam int DITHER_DEF    = 2000000;
  localparam int PERIOD_W      = 16 + FRAC_BITS;
  localparam int MIX_W         = FRAC_BITS + 1;
  localparam int NUM_W         = 90;
  localparam int MUL_W         = 33;
  localparam int DVS_W         = 30;
  localparam int GAIN_W        = 24;
  localparam int RATE_W        = 27;
  localparam int CFG_IDX_W     = 2;
  localparam int US_PER_SEC    = 1000000;

  localparam logic [GAIN_W-1:0] KP_RESET   = 24'd393216;
  localparam logic [GAIN_W-1:0] KI_RESET   = 24'd327680;
  localparam logic [RATE_W-1:0] RATE_RESET = 27'd1000000;

  localparam logic [CFG_IDX_W-1:0] CFG_KP   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_KI   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_RATE = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_DSET,
    ST_DIV,
    ST_POST,
    ST_OUT
  } state_t;

  typedef enum logic [3:0] {
    OP_CNT,
    OP_KP,
    OP_KI,
    OP_B,
    OP_A,
    OP_Q,
    OP_DTH,
    OP_MIXS,
    OP_MIX
  } op_t;

endpackage
`default_nettype wire

// ----- src/clock_servo_fractional_divider.sv -----
// Clock servo with a PI loop that steers a fractional clock divider.
// One sample is worked on at a time: in_tready is high only in the idle state.
// A corrected sample uses a shared shift-add multiplier up to six times and a
// restoring divider up to four times, in turn; a first sample uses each once.
// Synchronous active-low reset restores gains, tick rate, history and period.
`timescale 1ns / 1ps
`default_nettype none
module clock_servo_fractional_divider
  import csfd_pkg::*;
#(
  parameter int DITHER_STEPS = DITHER_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [RATE_W-1:0]    cfg_wdata,
  input  wire logic                 in_tvalid,
  output      logic                 in_tready,
  input  wire logic [127:0]         in_tdata,   // host_time_us, counter_ticks
  output      logic                 out_tvalid,
  input  wire logic                 out_tready,
  output      logic [127:0]         out_tdata,  // divider_first, divider_second,
                                                // mix_word, offset_error_us
  output      logic                 out_tuser   // adjusted
);

  `include "clock_servo_fractional_divider_assert.svh"

  localparam int CW   = $clog2(DITHER_STEPS + 1);
  localparam int SW   = $clog2(NUM_W + 1);
  localparam logic [PERIOD_W-1:0] PMIN  = PERIOD_W'(2) << FRAC_BITS;
  localparam logic [PERIOD_W-1:0] PMAX  = PERIOD_W'(65535) << FRAC_BITS;
  localparam logic [PERIOD_W-1:0] PRST  = PERIOD_W'(125) << (FRAC_BITS - 1);
  localparam logic [PERIOD_W:0]   PHALF = (PERIOD_W+1)'(1) << (FRAC_BITS - 1);
  localparam logic [NUM_W-1:0]    DHALF = (NUM_W'(1) << (FRAC_BITS - 1)) - NUM_W'(1);
  localparam logic [MUL_W-1:0]    BSCL  = MUL_W'(1) << (FRAC_BITS - 16);

  state_t state_r, state_nxt;
  op_t    op_r, op_nxt;

  logic [GAIN_W-1:0]   kp_r, kp_nxt, ki_r, ki_nxt;
  logic [RATE_W-1:0]   rate_r, rate_nxt;
  logic [63:0]         last_host_r, last_host_nxt, last_cnt_r, last_cnt_nxt;
  logic [PERIOD_W-1:0] period_r, period_nxt;

  logic [NUM_W-1:0]    acc_r, acc_nxt;
  logic [63:0]         mx_r, mx_nxt;
  logic [MUL_W-1:0]    mm_r, mm_nxt;
  logic [SW-1:0]       stp_r, stp_nxt;
  logic [DVS_W-1:0]    rem_r, rem_nxt, dvs_r, dvs_nxt;
  logic [63:0]         quo_r, quo_nxt;
  logic                qovf_r, qovf_nxt;

  logic [63:0]         host_r, host_nxt, cnt_us_r, cnt_us_nxt;
  logic [47:0]         ofs_r, ofs_nxt;
  logic                et_neg_r, et_neg_nxt, ei_neg_r, ei_neg_nxt;
  logic [31:0]         et_mag_r, et_mag_nxt;
  logic [57:0]         p1_r, p1_nxt;
  logic                sneg_r, sneg_nxt;
  logic [63:0]         b_r, b_nxt;
  logic [PERIOD_W-1:0] p_r, p_nxt;
  logic [15:0]         k1_r, k1_nxt, k2_r, k2_nxt;
  logic [MIX_W-1:0]    mix_r, mix_nxt;
  logic                adj_r, adj_nxt;
  logic [CW-1:0]       c_r, c_nxt;

  logic                ov_r, ov_nxt;
  logic [127:0]        od_r, od_nxt;
  logic                ou_r, ou_nxt;

  logic [RATE_W-1:0]   rate_eff;
  logic [63:0]         qsat;
  logic [DVS_W:0]      dtrial;
  logic                dge;
  logic                tneg;
  logic [63:0]         tmag, iraw, imag;
  logic [31:0]         ei_mag;
  logic [57:0]         acc58, p2, ssum, smag;
  logic [64:0]         sum_ab;
  logic [63:0]         pv;
  logic [PERIOD_W:0]   kr_sum;
  logic [15:0]         kr;
  logic [PERIOD_W-1:0] base;
  logic [NUM_W-1:0]    dpart;

  function automatic logic [31:0] sat32(input logic neg, input logic [63:0] mag);
    logic [31:0] res;
    if (neg) begin
      res = (mag > 64'h8000_0000) ? 32'h8000_0000 : mag[31:0];
    end else begin
      res = (mag > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : mag[31:0];
    end
    return res;
  endfunction

  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = ov_r;
  assign out_tdata  = od_r;
  assign out_tuser  = ou_r;

  always_comb begin
    rate_eff = (rate_r == '0) ? RATE_W'(1) : rate_r;
    qsat     = qovf_r ? '1 : quo_r;
    dtrial   = {rem_r, acc_r[NUM_W-1]};
    dge      = dtrial >= {1'b0, dvs_r};
    tneg     = qsat < host_r;
    tmag     = tneg ? host_r - qsat : qsat - host_r;
    iraw     = (qsat - last_cnt_r) - (host_r - last_host_r);
    imag     = iraw[63] ? 64'd0 - iraw : iraw;
    ei_mag   = sat32(iraw[63], imag);
    acc58    = acc_r[57:0];
    p2       = et_neg_r ? 58'd0 - acc58 : acc58;
    ssum     = p1_r + p2;
    smag     = ssum[57] ? 58'd0 - ssum : ssum;
    sum_ab   = {1'b0, qsat} + {1'b0, b_r};
    if (sneg_r) begin
      pv = (qsat > b_r) ? qsat - b_r : 64'd0;
    end else begin
      pv = sum_ab[64] ? '1 : sum_ab[63:0];
    end
    kr_sum   = {1'b0, p_r} + PHALF;
    kr       = kr_sum[FRAC_BITS +: 16];
    base     = {kr, FRAC_BITS'(0)};
    dpart    = (acc_r + DHALF) >> FRAC_BITS;
  end

  always_comb begin
    state_nxt     = state_r;
    op_nxt        = op_r;
    kp_nxt        = kp_r;
    ki_nxt        = ki_r;
    rate_nxt      = rate_r;
    last_host_nxt = last_host_r;
    last_cnt_nxt  = last_cnt_r;
    period_nxt    = period_r;
    acc_nxt       = acc_r;
    mx_nxt        = mx_r;
    mm_nxt        = mm_r;
    stp_nxt       = stp_r;
    rem_nxt       = rem_r;
    dvs_nxt       = dvs_r;
    quo_nxt       = quo_r;
    qovf_nxt      = qovf_r;
    host_nxt      = host_r;
    cnt_us_nxt    = cnt_us_r;
    ofs_nxt       = ofs_r;
    et_neg_nxt    = et_neg_r;
    et_mag_nxt    = et_mag_r;
    ei_neg_nxt    = ei_neg_r;
    p1_nxt        = p1_r;
    sneg_nxt      = sneg_r;
    b_nxt         = b_r;
    p_nxt         = p_r;
    k1_nxt        = k1_r;
    k2_nxt        = k2_r;
    mix_nxt       = mix_r;
    adj_nxt       = adj_r;
    c_nxt         = c_r;
    ov_nxt        = ov_r;
    od_nxt        = od_r;
    ou_nxt        = ou_r;

    if (ov_r && out_tready) begin
      ov_nxt = 1'b0;
    end

    if (cfg_we) begin
      case (cfg_index)
        CFG_KP:   kp_nxt   = cfg_wdata[GAIN_W-1:0];
        CFG_KI:   ki_nxt   = cfg_wdata[GAIN_W-1:0];
        CFG_RATE: rate_nxt = cfg_wdata;
        default:  ;
      endcase
    end

    case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          host_nxt  = in_tdata[63:0];
          acc_nxt   = '0;
          mx_nxt    = in_tdata[127:64];
          mm_nxt    = MUL_W'(US_PER_SEC);
          stp_nxt   = SW'(MUL_W);
          op_nxt    = OP_CNT;
          state_nxt = ST_MUL;
        end
      end
      ST_MUL: begin
        acc_nxt = (acc_r << 1) + (mm_r[MUL_W-1] ? NUM_W'(mx_r) : NUM_W'(0));
        mm_nxt  = mm_r << 1;
        stp_nxt = stp_r - SW'(1);
        if (stp_r == SW'(1)) begin
          if (op_r == OP_CNT || op_r == OP_B || op_r == OP_A) begin
            state_nxt = ST_DSET;
          end else begin
            state_nxt = ST_POST;
          end
        end
      end
      ST_DSET: begin
        if (op_r == OP_B) begin
          acc_nxt = (acc_r << 1) + NUM_W'({rate_eff, 1'b0});
          dvs_nxt = DVS_W'({rate_eff, 2'b00});
        end else begin
          acc_nxt = (acc_r << 1) + NUM_W'(rate_eff);
          dvs_nxt = DVS_W'({rate_eff, 1'b0});
        end
        rem_nxt   = '0;
        quo_nxt   = '0;
        qovf_nxt  = 1'b0;
        stp_nxt   = SW'(NUM_W);
        state_nxt = ST_DIV;
      end
      ST_DIV: begin
        rem_nxt  = dge ? DVS_W'(dtrial - {1'b0, dvs_r}) : DVS_W'(dtrial);
        acc_nxt  = acc_r << 1;
        quo_nxt  = {quo_r[62:0], dge};
        qovf_nxt = qovf_r | quo_r[63];
        stp_nxt  = stp_r - SW'(1);
        if (stp_r == SW'(1)) begin
          state_nxt = ST_POST;
        end
      end
      ST_POST: begin
        case (op_r)
          OP_CNT: begin
            cnt_us_nxt = qsat;
            if (tneg) begin
              ofs_nxt = 48'd0 - ((tmag > 64'h8000_0000_0000) ? 48'h8000_0000_0000 : tmag[47:0]);
            end else begin
              ofs_nxt = (tmag > 64'h7FFF_FFFF_FFFF) ? 48'h7FFF_FFFF_FFFF : tmag[47:0];
            end
            et_neg_nxt = tneg;
            et_mag_nxt = sat32(tneg, tmag);
            ei_neg_nxt = iraw[63];
            if (last_host_r == '0) begin
              k1_nxt    = '0;
              k2_nxt    = '0;
              mix_nxt   = '0;
              adj_nxt   = 1'b0;
              state_nxt = ST_OUT;
            end else begin
              acc_nxt   = '0;
              mx_nxt    = 64'(ei_mag);
              mm_nxt    = MUL_W'(kp_r);
              stp_nxt   = SW'(MUL_W);
              op_nxt    = OP_KP;
              state_nxt = ST_MUL;
            end
          end
          OP_KP: begin
            p1_nxt    = ei_neg_r ? 58'd0 - acc58 : acc58;
            acc_nxt   = '0;
            mx_nxt    = 64'(et_mag_r);
            mm_nxt    = MUL_W'(ki_r);
            stp_nxt   = SW'(MUL_W);
            op_nxt    = OP_KI;
            state_nxt = ST_MUL;
          end
          OP_KI: begin
            sneg_nxt  = ssum[57];
            acc_nxt   = '0;
            mx_nxt    = 64'(smag);
            mm_nxt    = BSCL;
            stp_nxt   = SW'(MUL_W);
            op_nxt    = OP_B;
            state_nxt = ST_MUL;
          end
          OP_B: begin
            b_nxt     = qsat;
            acc_nxt   = '0;
            mx_nxt    = 64'(period_r);
            mm_nxt    = MUL_W'(US_PER_SEC);
            stp_nxt   = SW'(MUL_W);
            op_nxt    = OP_A;
            state_nxt = ST_MUL;
          end
          OP_A: begin
            if (pv < 64'(PMIN)) begin
              p_nxt = PMIN;
            end else if (pv > 64'(PMAX)) begin
              p_nxt = PMAX;
            end else begin
              p_nxt = pv[PERIOD_W-1:0];
            end
            op_nxt = OP_Q;
          end
          OP_Q: begin
            k1_nxt = kr;
            if (p_r < base) begin
              k2_nxt    = kr - 16'd1;
              acc_nxt   = '0;
              mx_nxt    = 64'(base - p_r);
              mm_nxt    = MUL_W'(DITHER_STEPS);
              stp_nxt   = SW'(MUL_W);
              op_nxt    = OP_DTH;
              state_nxt = ST_MUL;
            end else if (p_r > base) begin
              k2_nxt    = kr + 16'd1;
              acc_nxt   = '0;
              mx_nxt    = 64'(p_r - base);
              mm_nxt    = MUL_W'(DITHER_STEPS);
              stp_nxt   = SW'(MUL_W);
              op_nxt    = OP_DTH;
              state_nxt = ST_MUL;
            end else begin
              k2_nxt = kr;
              c_nxt  = CW'(DITHER_STEPS / 2);
              op_nxt = OP_MIXS;
            end
          end
          OP_DTH: begin
            c_nxt  = CW'(DITHER_STEPS) - dpart[CW-1:0];
            op_nxt = OP_MIXS;
          end
          OP_MIXS: begin
            acc_nxt   = (NUM_W'(c_r) << (FRAC_BITS + 1)) + NUM_W'(DITHER_STEPS);
            dvs_nxt   = DVS_W'(2 * DITHER_STEPS);
            rem_nxt   = '0;
            quo_nxt   = '0;
            qovf_nxt  = 1'b0;
            stp_nxt   = SW'(NUM_W);
            op_nxt    = OP_MIX;
            state_nxt = ST_DIV;
          end
          OP_MIX: begin
            mix_nxt = qsat[MIX_W-1:0];
            if (k1_r > k2_r) begin
              period_nxt = {k2_r, FRAC_BITS'(0)} + PERIOD_W'(qsat[MIX_W-1:0]);
            end else if (k1_r < k2_r) begin
              period_nxt = {k2_r, FRAC_BITS'(0)} - PERIOD_W'(qsat[MIX_W-1:0]);
            end else begin
              period_nxt = {k2_r, FRAC_BITS'(0)};
            end
            adj_nxt   = 1'b1;
            state_nxt = ST_OUT;
          end
          default: state_nxt = ST_IDLE;
        endcase
      end
      ST_OUT: begin
        if (!ov_r || out_tready) begin
          ov_nxt        = 1'b1;
          od_nxt        = {3'b000, ofs_r, mix_r, k2_r, k1_r};
          ou_nxt        = adj_r;
          last_host_nxt = host_r;
          last_cnt_nxt  = cnt_us_r;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      op_r        <= OP_CNT;
      kp_r        <= KP_RESET;
      ki_r        <= KI_RESET;
      rate_r      <= RATE_RESET;
      last_host_r <= '0;
      last_cnt_r  <= '0;
      period_r    <= PRST;
      stp_r       <= '0;
      ov_r        <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      op_r        <= op_nxt;
      kp_r        <= kp_nxt;
      ki_r        <= ki_nxt;
      rate_r      <= rate_nxt;
      last_host_r <= last_host_nxt;
      last_cnt_r  <= last_cnt_nxt;
      period_r    <= period_nxt;
      stp_r       <= stp_nxt;
      ov_r        <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    acc_r    <= acc_nxt;
    mx_r     <= mx_nxt;
    mm_r     <= mm_nxt;
    rem_r    <= rem_nxt;
    dvs_r    <= dvs_nxt;
    quo_r    <= quo_nxt;
    qovf_r   <= qovf_nxt;
    host_r   <= host_nxt;
    cnt_us_r <= cnt_us_nxt;
    ofs_r    <= ofs_nxt;
    et_neg_r <= et_neg_nxt;
    et_mag_r <= et_mag_nxt;
    ei_neg_r <= ei_neg_nxt;
    p1_r     <= p1_nxt;
    sneg_r   <= sneg_nxt;
    b_r      <= b_nxt;
    p_r      <= p_nxt;
    k1_r     <= k1_nxt;
    k2_r     <= k2_nxt;
    mix_r    <= mix_nxt;
    adj_r    <= adj_nxt;
    c_r      <= c_nxt;
    od_r     <= od_nxt;
    ou_r     <= ou_nxt;
  end

  `CSFD_ASSERT_IMP(a_first_zero, out_tvalid && !out_tuser, out_tdata[76:0] == 77'd0, "first sample carries divider words")
  `CSFD_ASSERT_IMP(a_adj_div_min, out_tvalid && out_tuser, out_tdata[15:0] >= 16'd2, "corrected divider below two")
  `CSFD_ASSERT_NXT(a_busy_after_beat, in_tvalid && in_tready, !in_tready, "second beat taken while busy")
  `CSFD_ASSERT_IMP(a_div_nonzero, state_r == ST_DIV, dvs_r != '0, "divider runs with a zero divisor")

endmodule
`default_nettype wire
